// ----- sv/gfr_pkg.sv -----
// ----------------------------------------------------------------------------
// gfr_pkg: shared types and constants of the gaussian fit residual block
// Register indexes, fixed-point constants of the exponential unit and the
// side-band records that travel with a transaction through the pipeline.
// ----------------------------------------------------------------------------
package gfr_pkg;

  typedef enum logic [7:0] {
    REG_OFFSET_LEVEL = 8'd0,
    REG_PEAK_HEIGHT  = 8'd1,
    REG_PEAK_CENTER  = 8'd2,
    REG_PEAK_WIDTH   = 8'd3
  } cfg_reg_t;

  localparam logic [31:0] OFFSET_RST = 32'h0000_0000;
  localparam logic [31:0] HEIGHT_RST = 32'h0001_0000;
  localparam logic [31:0] CENTER_RST = 32'h0000_0000;
  localparam logic [30:0] WIDTH_RST  = 31'h0001_0000;

  // ln 2 in Q2.30, and the reduced argument bound past which 2^-k underflows
  localparam int unsigned ZW         = 41;
  localparam int unsigned K_BITS     = 5;
  localparam int unsigned POLY_TERMS = 12;
  localparam logic [ZW-1:0] LN2_Q30  = 41'd744261118;
  localparam logic [ZW-1:0] Z_LIMIT  = 41'd744261118 * 41'd31;
  localparam logic [30:0]   ONE30    = 31'h4000_0000;

  typedef struct packed {
    logic [31:0] y;
    logic [30:0] err;
    logic        last;
  } pt_side_t;

  typedef struct packed {
    pt_side_t pt;
    logic     uzero;
    logic     ezero;
  } d1_side_t;

  typedef struct packed {
    logic [31:0] fc;
    logic        satm;
    logic        neg;
    logic        udz;
    logic        ovf;
    logic        last;
  } d2_side_t;

  typedef struct packed {
    logic [31:0] model_value;
    logic [31:0] residual;
    logic        saturated;
    logic        last;
  } res_t;

endpackage

// ----- sv/gfr_div.sv -----
// ----------------------------------------------------------------------------
// gfr_div: pipelined restoring divider
// One quotient bit per register stage; the partial remainder, divisor and
// side-band data advance together under a common enable.
// ----------------------------------------------------------------------------
module gfr_div #(
  parameter int DW = 31,
  parameter int QW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          v_r    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [DW-1:0] div_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          v_src;
    logic [DW-1:0] rem_src;
    logic [QW-1:0] low_src;
    logic [QW-1:0] q_src;
    logic [DW-1:0] div_src;
    logic [SW-1:0] side_src;
    logic [DW:0]   rem_ext;
    logic          ge;
    logic [DW:0]   rem_nxt;

    if (j == 0) begin : g_first
      assign v_src    = in_valid;
      assign rem_src  = in_rem;
      assign low_src  = in_low;
      assign q_src    = '0;
      assign div_src  = in_div;
      assign side_src = in_side;
    end else begin : g_next
      assign v_src    = v_r[j-1];
      assign rem_src  = rem_r[j-1];
      assign low_src  = low_r[j-1];
      assign q_src    = q_r[j-1];
      assign div_src  = div_r[j-1];
      assign side_src = side_r[j-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      rem_ext = {rem_src, low_src[QW-1]};
      ge      = (rem_ext >= {1'b0, div_src});
      rem_nxt = ge ? (rem_ext - {1'b0, div_src}) : rem_ext;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt[DW-1:0];
        low_r[j]  <= {low_src[QW-2:0], 1'b0};
        q_r[j]    <= {q_src[QW-2:0], ge};
        div_r[j]  <= div_src;
        side_r[j] <= side_src;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot  = q_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ----- sv/gfr_exp.sv -----
// ----------------------------------------------------------------------------
// gfr_exp: pipelined exp(-u^2/2) unit
// Squares u, reduces by ln 2 one quotient bit a stage, then runs a Horner
// polynomial in Q1.30 with two register stages per term.
// ----------------------------------------------------------------------------
module gfr_exp
  import gfr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [FRAC_BITS+5:0] in_u,
  input  logic                 in_ezero,
  input  pt_side_t             in_side,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   out_e,
  output pt_side_t             out_side
);

  localparam int UW   = FRAC_BITS + 6;
  localparam int S_K0 = 2;
  localparam int S_P0 = S_K0 + K_BITS;
  localparam int S_E  = S_P0 + 2 * POLY_TERMS;
  localparam int NS   = S_E + 1;
  localparam int PS   = 2 * POLY_TERMS;

  logic     v_r    [NS];
  logic     ez_r   [NS];
  pt_side_t side_r [NS];

  logic [2*UW-1:0]  u2_r;
  logic [ZW-1:0]    z_r;
  logic [ZW-1:0]    kr_r [K_BITS];
  logic [K_BITS-1:0] kk_r [K_BITS];
  logic [29:0]      m_r  [POLY_TERMS];
  logic [30:0]      pp_r [POLY_TERMS];
  logic [29:0]      pr_r [PS];
  logic [K_BITS-1:0] pk_r [PS];
  logic [FRAC_BITS:0] e_r;

  logic [ZW-1:0] z_nxt;

  // square stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_r      <= {{UW{1'b0}}, in_u} * {{UW{1'b0}}, in_u};
      ez_r[0]   <= in_ezero;
      side_r[0] <= in_side;
    end
  end

  // drop the -0.5 factor into the shift, move to Q30
  assign z_nxt = ZW'(u2_r[2*UW-1:FRAC_BITS+1]) << (30 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[1] <= 1'b0;
    end else if (en) begin
      v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r       <= z_nxt;
      ez_r[1]   <= ez_r[0] | (z_nxt >= Z_LIMIT);
      side_r[1] <= side_r[0];
    end
  end

  // control and side band for all later stages
  for (genvar s = S_K0; s < NS; s++) begin : g_pass
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ez_r[s]   <= ez_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // range reduction: k = floor(Z / ln2), one bit a stage
  for (genvar j = 0; j < K_BITS; j++) begin : g_kred
    localparam int B = K_BITS - 1 - j;
    localparam logic [ZW-1:0] STEP = LN2_Q30 << B;
    logic [ZW-1:0]     rem_src;
    logic [K_BITS-1:0] k_src;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_src = z_r;
      assign k_src   = '0;
    end else begin : g_next
      assign rem_src = kr_r[j-1];
      assign k_src   = kk_r[j-1];
    end

    assign ge = (rem_src >= STEP);

    always_ff @(posedge clk) begin
      if (en) begin
        kr_r[j] <= ge ? (rem_src - STEP) : rem_src;
        kk_r[j] <= k_src | (K_BITS'(ge) << B);
      end
    end
  end

  // Horner: p = 1 - (r*p)/i, i counting down; /i is a reciprocal multiply
  for (genvar t = 0; t < POLY_TERMS; t++) begin : g_poly
    localparam int unsigned DIVI = POLY_TERMS - t;
    localparam int unsigned SH   = $clog2(DIVI);
    localparam logic [31:0] MUL  = 32'(((64'd1 << (30 + SH)) / DIVI) + 64'd1);
    logic [29:0]       r_src;
    logic [K_BITS-1:0] k_src;
    logic [30:0]       p_src;
    logic [60:0]       rp;
    logic [63:0]       mq;
    logic [29:0]       q;

    if (t == 0) begin : g_first
      assign r_src = kr_r[K_BITS-1][29:0];
      assign k_src = kk_r[K_BITS-1];
      assign p_src = ONE30;
    end else begin : g_next
      assign r_src = pr_r[2*t-1];
      assign k_src = pk_r[2*t-1];
      assign p_src = pp_r[t-1];
    end

    assign rp = {31'd0, r_src} * {30'd0, p_src};
    assign mq = {34'd0, m_r[t]} * {32'd0, MUL};
    assign q  = mq[30+SH +: 30];

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[t]      <= rp[59:30];
        pr_r[2*t]   <= r_src;
        pk_r[2*t]   <= k_src;
        pp_r[t]     <= ONE30 - {1'b0, q};
        pr_r[2*t+1] <= pr_r[2*t];
        pk_r[2*t+1] <= pk_r[2*t];
      end
    end
  end

  // scale by 2^-k and round to FRAC_BITS
  logic [30:0] e30;
  logic [31:0] e_sum;

  always_comb begin
    e30   = pp_r[POLY_TERMS-1] >> pk_r[PS-1];
    e_sum = {1'b0, e30} + (32'd1 << (29 - FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= ez_r[S_E-1] ? '0 : e_sum[30-FRAC_BITS +: FRAC_BITS+1];
    end
  end

  assign out_valid = v_r[S_E];
  assign out_e     = e_r;
  assign out_side  = side_r[S_E];

endmodule

// ----- sv/gfr_skid.sv -----
// ----------------------------------------------------------------------------
// gfr_skid: two-entry output buffer
// Parts the pipeline from the result channel; the pipeline holds only when
// both entries are occupied.
// ----------------------------------------------------------------------------
module gfr_skid
  import gfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  res_t in_data,
  output logic ready,
  output logic out_valid,
  output res_t out_data,
  input  logic out_stall
);

  res_t       buf_r [2];
  logic [1:0] cnt_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       push;
  logic       pop;

  assign ready     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rd_ptr_r];
  assign push      = in_valid & ready;
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= in_data;
  end

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("skid count did not advance on push");

  a_cnt_dn: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("skid count did not drop on pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("skid pointers disagree with count");

endmodule

// ----- sv/gaussian_fit_residual.sv -----
// ----------------------------------------------------------------------------
// gaussian_fit_residual: gaussian model value and weighted residual
// Evaluates f = offset + peak*exp(-(x-center)^2/(2 width^2)) per point and
// returns f with (y - f)/error, both saturated to 32-bit fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one data point per transaction (x, y, error, last
//   mark), taken when in_valid is high and in_stall is low.
//   Result channel out_*: one result per point, in order, taken when
//   out_valid is high and out_stall is low.
//   Config channel cfg_*: cfg_ready is always high; write registers only
//   while no transaction is in flight.
// Throughput: one transaction per cycle while the output buffer has room.
// Pipeline: three setup stages, the two bit-serial dividers (FRAC_BITS+6
//   and 32 stages), the 32-stage exponential unit, seven model and
//   residual stages and the output buffer.
// Reset: clears all valid bits and the output buffer and loads the register
//   defaults (offset 0, height 1.0, center 0, width 1.0).
// Stall: a two-entry output buffer absorbs a stalled result; the pipeline
//   holds as a whole only when both entries are full, losing nothing.
// ----------------------------------------------------------------------------
module gaussian_fit_residual
  import gfr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_x,
  input  logic [31:0] in_sample_y,
  input  logic [30:0] in_sample_error,
  input  logic        in_last_point,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_model_value,
  output logic [31:0] out_residual,
  output logic        out_saturated,
  output logic        out_last_out,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int UW  = FRAC_BITS + 6;   // width of the scaled distance u
  localparam int CW2 = 63 - FRAC_BITS;  // compare width of the residual bound

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] offset_r;
  logic [31:0] height_r;
  logic [31:0] center_r;
  logic [30:0] width_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      height_r <= HEIGHT_RST;
      center_r <= CENTER_RST;
      width_r  <= WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OFFSET_LEVEL: offset_r <= cfg_data;
        REG_PEAK_HEIGHT:  height_r <= cfg_data;
        REG_PEAK_CENTER:  center_r <= cfg_data;
        REG_PEAK_WIDTH:   width_r  <= cfg_data[30:0];
        default:          ;
      endcase
    end
  end

  // Derived terms: magnitude and sign of the peak, width scaled by 64 for
  // the out-of-range test. They settle long before any point reaches them.
  logic [31:0] peak_abs_r;
  logic        peak_neg_r;
  logic [36:0] width_sh_r;

  always_ff @(posedge clk) begin
    peak_neg_r <= height_r[31];
    peak_abs_r <= height_r[31] ? (~height_r + 32'd1) : height_r;
    width_sh_r <= {width_r, 6'b0};
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: everything advances unless the output buffer is full
  // --------------------------------------------------------------------------
  logic en;
  assign in_stall = ~en;

  // T0: distance from the center
  logic        v0_r;
  logic [32:0] d_r;
  pt_side_t    pt0_r;

  // T1: absolute distance
  logic        v1_r;
  logic [32:0] ad_r;
  pt_side_t    pt1_r;

  // T2: range test and divider setup for u = |d| / width
  logic        v2_r;
  logic [30:0] d1_rem_r;
  logic [UW-1:0] d1_low_r;
  d1_side_t    d1s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r        <= {in_sample_x[31], in_sample_x} - {center_r[31], center_r};
      pt0_r.y    <= in_sample_y;
      pt0_r.err  <= in_sample_error;
      pt0_r.last <= in_last_point;

      ad_r  <= d_r[32] ? (~d_r + 33'd1) : d_r;
      pt1_r <= pt0_r;

      // u >= 64 flushes the exponential; zero distance forces u = 0,
      // which also covers a zero width
      d1s_r.pt    <= pt1_r;
      d1s_r.uzero <= (ad_r == 33'd0);
      d1s_r.ezero <= ({4'b0, ad_r} >= width_sh_r) && (ad_r != 33'd0);
      d1_rem_r    <= {4'b0, ad_r[32:6]};
      d1_low_r    <= {ad_r[5:0], {FRAC_BITS{1'b0}}};
    end
  end

  // --------------------------------------------------------------------------
  // u = floor(|d| * 2^F / width), one bit a stage
  // --------------------------------------------------------------------------
  logic                  d1_valid;
  logic [UW-1:0]         d1_quot;
  logic [$bits(d1_side_t)-1:0] d1_side_vec;
  d1_side_t              d1_out;

  gfr_div #(
    .DW (31),
    .QW (UW),
    .SW ($bits(d1_side_t))
  ) u_div_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rem    (d1_rem_r),
    .in_low    (d1_low_r),
    .in_div    (width_r),
    .in_side   (d1s_r),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_side  (d1_side_vec)
  );

  assign d1_out = d1_side_t'(d1_side_vec);

  // --------------------------------------------------------------------------
  // Exponential
  // --------------------------------------------------------------------------
  logic               ex_valid;
  logic [FRAC_BITS:0] ex_e;
  pt_side_t           ex_side;

  gfr_exp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d1_valid),
    .in_u      (d1_out.uzero ? '0 : d1_quot),
    .in_ezero  (d1_out.ezero),
    .in_side   (d1_out.pt),
    .out_valid (ex_valid),
    .out_e     (ex_e),
    .out_side  (ex_side)
  );

  // --------------------------------------------------------------------------
  // Model value
  // --------------------------------------------------------------------------
  // T3: |peak| * E
  logic                  v3_r;
  logic [32+FRAC_BITS:0] mag_r;
  pt_side_t              pt3_r;

  // T4: round half up on the magnitude
  logic        v4_r;
  logic [31:0] t_r;
  pt_side_t    pt4_r;

  // T5: apply sign, add baseline, clip
  logic        v5_r;
  logic [31:0] fc_r;
  logic        satm_r;
  pt_side_t    pt5_r;

  // T6: y - f
  logic        v6_r;
  logic [32:0] diff_r;
  logic [31:0] fc6_r;
  logic        satm6_r;
  pt_side_t    pt6_r;

  // T7: |y - f|
  logic        v7_r;
  logic [32:0] ud_r;
  logic        neg7_r;
  logic [31:0] fc7_r;
  logic        satm7_r;
  pt_side_t    pt7_r;

  // T8: overflow test and divider setup for the residual
  logic        v8_r;
  logic [30:0] d2_rem_r;
  logic [31:0] d2_low_r;
  logic [30:0] d2_div_r;
  d2_side_t    d2s_r;

  logic [33+FRAC_BITS:0] rnd_sum;
  logic signed [33:0]    f_full;
  logic [31:0]           fc_nxt;
  logic                  satm_nxt;

  always_comb begin
    rnd_sum = {1'b0, mag_r} + ((34+FRAC_BITS)'(1) << (FRAC_BITS - 1));
    f_full  = peak_neg_r ? ($signed({{2{offset_r[31]}}, offset_r}) - $signed({2'b0, t_r}))
                         : ($signed({{2{offset_r[31]}}, offset_r}) + $signed({2'b0, t_r}));
    priority if (f_full > 34'sh0_7FFF_FFFF) begin
      fc_nxt   = 32'h7FFF_FFFF;
      satm_nxt = 1'b1;
    end else if (f_full < -34'sh0_8000_0000) begin
      fc_nxt   = 32'h8000_0000;
      satm_nxt = 1'b1;
    end else begin
      fc_nxt   = f_full[31:0];
      satm_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v3_r <= ex_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= {{(FRAC_BITS+1){1'b0}}, peak_abs_r} * {32'd0, ex_e};
      pt3_r <= ex_side;

      t_r   <= rnd_sum[FRAC_BITS +: 32];
      pt4_r <= pt3_r;

      fc_r   <= fc_nxt;
      satm_r <= satm_nxt;
      pt5_r  <= pt4_r;

      diff_r  <= {pt5_r.y[31], pt5_r.y} - {fc_r[31], fc_r};
      fc6_r   <= fc_r;
      satm6_r <= satm_r;
      pt6_r   <= pt5_r;

      ud_r    <= diff_r[32] ? (~diff_r + 33'd1) : diff_r;
      neg7_r  <= diff_r[32];
      fc7_r   <= fc6_r;
      satm7_r <= satm6_r;
      pt7_r   <= pt6_r;

      // quotient of 2^32 or more clips either way; so does a zero error, unless y - f is zero
      d2s_r.fc   <= fc7_r;
      d2s_r.satm <= satm7_r;
      d2s_r.neg  <= neg7_r;
      d2s_r.udz  <= (ud_r == 33'd0);
      d2s_r.ovf  <= ({{(CW2-33){1'b0}}, ud_r} >= {pt7_r.err, {(32-FRAC_BITS){1'b0}}});
      d2s_r.last <= pt7_r.last;
      d2_rem_r   <= {{(30-FRAC_BITS){1'b0}}, ud_r[32:32-FRAC_BITS]};
      d2_low_r   <= {ud_r[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      d2_div_r   <= pt7_r.err;
    end
  end

  // --------------------------------------------------------------------------
  // Residual magnitude = floor(|y - f| * 2^F / error)
  // --------------------------------------------------------------------------
  logic                        d2_valid;
  logic [31:0]                 d2_quot;
  logic [$bits(d2_side_t)-1:0] d2_side_vec;
  d2_side_t                    d2_out;

  gfr_div #(
    .DW (31),
    .QW (32),
    .SW ($bits(d2_side_t))
  ) u_div_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .in_rem    (d2_rem_r),
    .in_low    (d2_low_r),
    .in_div    (d2_div_r),
    .in_side   (d2s_r),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_side  (d2_side_vec)
  );

  assign d2_out = d2_side_t'(d2_side_vec);

  // T9: sign and clip the residual, merge the flags
  logic        v9_r;
  res_t        res_r;
  logic [32:0] qv;
  logic [31:0] res_nxt;
  logic        satr_nxt;

  always_comb begin
    qv = d2_out.ovf ? 33'h1_0000_0000 : {1'b0, d2_quot};
    priority if (d2_out.udz) begin
      res_nxt  = 32'h0;
      satr_nxt = 1'b0;
    end else if (!d2_out.neg && (qv > 33'h0_7FFF_FFFF)) begin
      res_nxt  = 32'h7FFF_FFFF;
      satr_nxt = 1'b1;
    end else if (!d2_out.neg) begin
      res_nxt  = qv[31:0];
      satr_nxt = 1'b0;
    end else if (qv > 33'h0_8000_0000) begin
      res_nxt  = 32'h8000_0000;
      satr_nxt = 1'b1;
    end else begin
      res_nxt  = ~qv[31:0] + 32'd1;
      satr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.model_value <= d2_out.fc;
      res_r.residual    <= res_nxt;
      res_r.saturated   <= d2_out.satm | satr_nxt;
      res_r.last        <= d2_out.last;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer
  // --------------------------------------------------------------------------
  res_t out_data;

  gfr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v9_r),
    .in_data   (res_r),
    .ready     (en),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  assign out_model_value = out_data.model_value;
  assign out_residual    = out_data.residual;
  assign out_saturated   = out_data.saturated;
  assign out_last_out    = out_data.last;

endmodule
